// File: hdl/atht_pkg.sv
// ----------------------------------------------------------------------------
// Allocation tracker package
// Shared types, codes, constants and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package atht_pkg;

  localparam int unsigned HOME_W  = 20;
  localparam int unsigned BYTES_W = 48;
  localparam int unsigned COUNT_W = 32;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_ADD,
    B_RD,
    B_CHK,
    B_SUB,
    B_SHRD,
    B_SHCHK,
    B_DONE
  } back_state_e;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    logic              func;
    logic [31:0]       address;
    logic [31:0]       size;
    logic [4:0]        cls;
    logic [4:0]        phase;
    logic [HOME_W-1:0] home;
  } req_t;

  // Floor of log2; sizes zero and one both fall into class zero.
  function automatic logic [4:0] class_of(input logic [31:0] n);
    logic [4:0] c;
    c = '0;
    for (int b = 1; b < 32; b++) begin
      if (n[b]) c = 5'(b);
    end
    return c;
  endfunction

  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [47:0] sub_floor48(input logic [47:0] a, input logic [31:0] b);
    return (a > {16'd0, b}) ? a - {16'd0, b} : '0;
  endfunction

  function automatic logic [31:0] inc_sat32(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  function automatic logic [31:0] dec_floor32(input logic [31:0] a);
    return (a == '0) ? a : a - 32'd1;
  endfunction

endpackage

// File: hdl/atht_if.sv
// ----------------------------------------------------------------------------
// Allocation tracker channels
// Valid/ready channels for event requests and for result items.
// ----------------------------------------------------------------------------
interface atht_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] address;
  logic [31:0] size;

  modport source (output valid, func, address, size, input ready);
  modport sink   (input valid, func, address, size, output ready);
endinterface

interface atht_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] live_bytes;
  logic [31:0] live_count;
  logic [31:0] overflow_count;
  logic [4:0]  class_index;
  logic [31:0] class_count;
  logic [47:0] class_bytes;
  logic [47:0] phase_bytes;
  logic [31:0] phase_count;

  modport source (output valid, status, live_bytes, live_count, overflow_count, class_index,
                  class_count, class_bytes, phase_bytes, phase_count, input ready);
  modport sink   (input valid, status, live_bytes, live_count, overflow_count, class_index,
                  class_count, class_bytes, phase_bytes, phase_count, output ready);
endinterface

// File: hdl/atht_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module atht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/atht_front.sv
// ----------------------------------------------------------------------------
// Allocation tracker front end
// Accepts event requests, works out size class, phase tag and home slot.
// ----------------------------------------------------------------------------
module atht_front import atht_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned NUM_PHASES  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  atht_in_if.sink    in_i,
  input  logic [4:0] phase_i,
  input  logic       clear_busy_i,
  input  logic       full_i,
  output logic       push_o,
  output req_t       req_o
);

  localparam int unsigned IW      = $clog2(TABLE_SLOTS);
  localparam bit          IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam int unsigned SH      = 31 + IW;
  localparam logic [31:0] RECIP   = 32'((64'd1 << SH) / 64'(TABLE_SLOTS));
  localparam logic [31:0] SLOTS32 = 32'(TABLE_SLOTS);

  front_state_e   state_q, state_d;
  req_t           req_q;
  logic [31:0]    prod_q;
  logic [63:0]    qprod_q;
  logic [IW:0]    rem_q;
  logic [4:0]     cnt_q;
  logic [31:0]    quot;
  logic [IW:0]    rem_fix;
  logic           accept;

  // Reciprocal quotient estimate, low by at most one, and its correction.
  always_comb begin
    quot    = 32'(qprod_q >> SH);
    rem_fix = (rem_q >= (IW+1)'(TABLE_SLOTS)) ? rem_q - (IW+1)'(TABLE_SLOTS) : rem_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_i.valid && !clear_busy_i) state_d = F_MUL;
      F_MUL:   state_d = F_MOD;
      F_MOD:   if (IS_POW2 || cnt_q == 5'd2) state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_i.ready = (state_q == F_IDLE) && !clear_busy_i;
    push_o     = (state_q == F_PUSH) && !full_i;
  end

  assign accept = in_i.valid && in_i.ready;
  assign req_o  = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture, hash multiply and slot reduction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.func    <= in_i.func;
      req_q.address <= in_i.address;
      req_q.size    <= in_i.size;
      req_q.cls     <= class_of(in_i.size);
      req_q.phase   <= (32'(phase_i) < NUM_PHASES) ? phase_i : 5'd0;
    end
    if (state_q == F_MUL) begin
      prod_q <= {3'd0, req_q.address[31:3]} * HASH_MULT;
      cnt_q  <= '0;
    end
    if (state_q == F_MOD) begin
      if (IS_POW2) begin
        req_q.home <= HOME_W'(prod_q[IW-1:0]);
      end else begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd0) qprod_q <= {32'd0, prod_q} * {32'd0, RECIP};
        if (cnt_q == 5'd1) rem_q <= (IW+1)'(prod_q - quot * SLOTS32);
        if (cnt_q == 5'd2) req_q.home <= HOME_W'(rem_fix);
      end
    end
  end

endmodule

// File: hdl/atht_fifo.sv
// ----------------------------------------------------------------------------
// Allocation tracker request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module atht_fifo import atht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output req_t req_o
);

  req_t       ent_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign req_o   = ent_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= req_i;
  end

endmodule

// File: hdl/atht_back.sv
// ----------------------------------------------------------------------------
// Allocation tracker back end
// Updates counters, walks the slot table and performs backward-shift delete.
// ----------------------------------------------------------------------------
module atht_back import atht_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned NUM_PHASES  = 32,
  parameter int unsigned NUM_CLASSES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  req_t        req_i,
  output logic        pop_o,
  output logic        clear_busy_o,
  atht_out_if.source  out_o
);

  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned CW = $clog2(NUM_CLASSES);
  localparam int unsigned PW = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
  localparam int unsigned DW = 32 + 32 + 5 + IW;
  localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

  back_state_e    state_q, state_d;
  req_t           cur_q;
  logic [IW-1:0]  idx_q, hole_q, probe_q, clr_q;
  logic [31:0]    ent_size_q;
  logic [4:0]     ent_phase_q;
  logic [4:0]     cls_q, ph_q;
  status_e        status_q;

  logic [47:0]    live_bytes_q;
  logic [31:0]    live_count_q, ovf_q;
  logic [47:0]    cls_bytes_q [NUM_CLASSES];
  logic [31:0]    cls_count_q [NUM_CLASSES];
  logic [47:0]    ph_bytes_q  [NUM_PHASES];
  logic [31:0]    ph_count_q  [NUM_PHASES];

  logic           out_valid_q;
  logic           out_free;

  logic           ram_we;
  logic [IW-1:0]  ram_waddr;
  logic [DW-1:0]  ram_wdata, ram_rdata;
  logic [31:0]    rd_addr, rd_size;
  logic [4:0]     rd_phase;
  logic [IW-1:0]  rd_home;
  logic [IW-1:0]  idx_next;

  logic           store_hit, free_hit, walk_end, shift_stop, shift_move;

  logic           upd_add, upd_sub;
  logic [4:0]     upd_cls, upd_ph;
  logic [31:0]    upd_size;
  logic [CW-1:0]  ci;
  logic [PW-1:0]  pi;

  function automatic logic [IW-1:0] ring_dist(input logic [IW-1:0] from, input logic [IW-1:0] to);
    logic [IW:0] t;
    t = {1'b0, to} - {1'b0, from};
    if (to < from) t = t + (IW+1)'(TABLE_SLOTS);
    return t[IW-1:0];
  endfunction

  // Slot table: address, size, phase and home slot in one word.
  atht_ram #(.WIDTH(DW), .DEPTH(TABLE_SLOTS)) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_addr  = ram_rdata[DW-1 -: 32];
  assign rd_size  = ram_rdata[DW-33 -: 32];
  assign rd_phase = ram_rdata[IW+4 -: 5];
  assign rd_home  = ram_rdata[IW-1:0];
  assign idx_next = (idx_q == LAST) ? '0 : idx_q + 1'b1;
  assign out_free = !out_valid_q || out_o.ready;

  // Probe and shift decisions on the slot just read.
  always_comb begin
    store_hit  = (rd_addr == '0) || (rd_addr == cur_q.address);
    free_hit   = rd_addr == cur_q.address;
    walk_end   = probe_q == LAST;
    shift_stop = (idx_q == hole_q) || (rd_addr == '0);
    shift_move = ring_dist(rd_home, idx_q) >= ring_dist(hole_q, idx_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: if (clr_q == LAST) state_d = B_IDLE;
      B_IDLE: begin
        if (valid_i) begin
          if (req_i.address == '0)          state_d = B_DONE;
          else if (req_i.func == FUNC_ALLOC) state_d = B_ADD;
          else                               state_d = B_RD;
        end
      end
      B_ADD:   state_d = B_RD;
      B_RD:    state_d = B_CHK;
      B_CHK: begin
        if (cur_q.func == FUNC_ALLOC) begin
          state_d = (store_hit || walk_end) ? B_DONE : B_RD;
        end else if (free_hit) begin
          state_d = B_SUB;
        end else begin
          state_d = (rd_addr == '0 || walk_end) ? B_DONE : B_RD;
        end
      end
      B_SUB:   state_d = B_SHRD;
      B_SHRD:  state_d = B_SHCHK;
      B_SHCHK: state_d = shift_stop ? B_DONE : B_SHRD;
      B_DONE:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Control outputs: queue pop, table writes and counter update selection.
  always_comb begin
    pop_o        = (state_q == B_IDLE) && valid_i;
    clear_busy_o = state_q == B_CLEAR;
    ram_we       = 1'b0;
    ram_waddr    = hole_q;
    ram_wdata    = '0;
    upd_add      = 1'b0;
    upd_sub      = 1'b0;
    upd_cls      = cur_q.cls;
    upd_ph       = cur_q.phase;
    upd_size     = cur_q.size;
    unique case (state_q)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      B_ADD: upd_add = 1'b1;
      B_CHK: begin
        if (cur_q.func == FUNC_ALLOC && store_hit) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = {cur_q.address, cur_q.size, cur_q.phase, IW'(cur_q.home)};
        end
      end
      B_SUB: begin
        upd_sub  = 1'b1;
        upd_cls  = class_of(ent_size_q);
        upd_ph   = ent_phase_q;
        upd_size = ent_size_q;
      end
      B_SHCHK: begin
        if (shift_stop) begin
          ram_we = 1'b1;
        end else if (shift_move) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end
      end
      default: ;
    endcase
  end

  assign ci = CW'(upd_cls);
  assign pi = PW'(upd_ph);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Live totals and histograms.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_bytes_q <= '0;
      live_count_q <= '0;
      ovf_q        <= '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cls_bytes_q[k] <= '0;
        cls_count_q[k] <= '0;
      end
      for (int k = 0; k < NUM_PHASES; k++) begin
        ph_bytes_q[k] <= '0;
        ph_count_q[k] <= '0;
      end
    end else begin
      if (upd_add) begin
        live_bytes_q    <= add_sat48(live_bytes_q, upd_size);
        live_count_q    <= inc_sat32(live_count_q);
        cls_bytes_q[ci] <= add_sat48(cls_bytes_q[ci], upd_size);
        cls_count_q[ci] <= inc_sat32(cls_count_q[ci]);
        ph_bytes_q[pi]  <= add_sat48(ph_bytes_q[pi], upd_size);
        ph_count_q[pi]  <= inc_sat32(ph_count_q[pi]);
      end
      if (upd_sub) begin
        live_bytes_q    <= sub_floor48(live_bytes_q, upd_size);
        live_count_q    <= dec_floor32(live_count_q);
        cls_bytes_q[ci] <= sub_floor48(cls_bytes_q[ci], upd_size);
        cls_count_q[ci] <= dec_floor32(cls_count_q[ci]);
        ph_bytes_q[pi]  <= sub_floor48(ph_bytes_q[pi], upd_size);
        ph_count_q[pi]  <= dec_floor32(ph_count_q[pi]);
      end
      if (state_q == B_CHK && cur_q.func == FUNC_ALLOC && !store_hit && walk_end) begin
        ovf_q <= inc_sat32(ovf_q);
      end
    end
  end

  // Walk registers and request context.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == B_CLEAR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        cur_q    <= req_i;
        idx_q    <= IW'(req_i.home);
        probe_q  <= '0;
        status_q <= ST_IGNORED;
      end
      B_ADD: begin
        cls_q <= cur_q.cls;
        ph_q  <= cur_q.phase;
      end
      B_CHK: begin
        idx_q   <= idx_next;
        probe_q <= probe_q + 1'b1;
        if (cur_q.func == FUNC_ALLOC) begin
          if (store_hit)     status_q <= ST_DONE;
          else if (walk_end) status_q <= ST_FULL;
        end else if (free_hit) begin
          status_q    <= ST_DONE;
          hole_q      <= idx_q;
          ent_size_q  <= rd_size;
          ent_phase_q <= rd_phase;
        end
      end
      B_SUB: begin
        cls_q <= upd_cls;
        ph_q  <= upd_ph;
      end
      B_SHCHK: begin
        idx_q <= idx_next;
        if (!shift_stop && shift_move) hole_q <= idx_q;
      end
      default: ;
    endcase
  end

  // Result register; it holds until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == B_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_DONE && out_free) begin
      out_o.status         <= status_q;
      out_o.live_bytes     <= live_bytes_q;
      out_o.live_count     <= live_count_q;
      out_o.overflow_count <= ovf_q;
      if (status_q == ST_IGNORED) begin
        out_o.class_index <= '0;
        out_o.class_count <= '0;
        out_o.class_bytes <= '0;
        out_o.phase_bytes <= '0;
        out_o.phase_count <= '0;
      end else begin
        out_o.class_index <= cls_q;
        out_o.class_count <= cls_count_q[CW'(cls_q)];
        out_o.class_bytes <= cls_bytes_q[CW'(cls_q)];
        out_o.phase_bytes <= ph_bytes_q[PW'(ph_q)];
        out_o.phase_count <= ph_count_q[PW'(ph_q)];
      end
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

// File: hdl/allocation_tracking_hash_table.sv
// An event passes the front end (capture, hash multiply, home-slot reduction, push into
// the queue) and then the back end, which reads and checks one slot per probe and per slot
// visited by the shift delete; a table size that is not a power of two adds a reciprocal
// multiply and a remainder correction to the reduction. The front end can take a new request
// while the back end still works on earlier ones. After reset the slot table is cleared while
// no request is taken; counters, the phase register and all control state reset to zero at once.
// ----------------------------------------------------------------------------
// Allocation tracking hash table
// Front end, request queue and back end with an open-addressed slot table.
// ----------------------------------------------------------------------------
module allocation_tracking_hash_table import atht_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned NUM_PHASES  = 32,
  parameter int unsigned NUM_CLASSES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_data_i,
  atht_in_if.sink    in_i,
  atht_out_if.source out_o
);

  logic [4:0] phase_q;
  logic       clear_busy;
  logic       push, full, pop, q_valid;
  req_t       front_req, back_req;

  // Current phase register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cfg_we_i) begin
      phase_q <= cfg_data_i;
    end
  end

  atht_front #(.TABLE_SLOTS(TABLE_SLOTS), .NUM_PHASES(NUM_PHASES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .phase_i      (phase_q),
    .clear_busy_i (clear_busy),
    .full_i       (full),
    .push_o       (push),
    .req_o        (front_req)
  );

  atht_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (front_req),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .req_o   (back_req)
  );

  atht_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .NUM_PHASES  (NUM_PHASES),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .req_i        (back_req),
    .pop_o        (pop),
    .clear_busy_o (clear_busy),
    .out_o        (out_o)
  );

endmodule

// File: hdl/atht_chk.sv
// ----------------------------------------------------------------------------
// Allocation tracker checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module atht_chk import atht_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] overflow_count_i,
  input logic [4:0]  class_index_i,
  input logic [31:0] class_count_i,
  input logic [31:0] phase_count_i
);

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result withdrawn before it was taken");

  // Only the three defined status codes appear.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (status_i == ST_DONE || status_i == ST_IGNORED || status_i == ST_FULL))
    else $error("undefined status code");

  // An ignored request reports no affected block.
  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i == ST_IGNORED |->
      class_index_i == '0 && class_count_i == '0 && phase_count_i == '0)
    else $error("ignored request reports block statistics");

  // A full table always shows in the overflow count, and its class count is never zero.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i == ST_FULL |-> overflow_count_i != '0 && class_count_i != '0)
    else $error("table full without overflow count");

endmodule

bind allocation_tracking_hash_table atht_chk u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (out_o.valid),
  .ready_i          (out_o.ready),
  .status_i         (out_o.status),
  .overflow_count_i (out_o.overflow_count),
  .class_index_i    (out_o.class_index),
  .class_count_i    (out_o.class_count),
  .phase_count_i    (out_o.phase_count)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Allocation tracker testbench
// Drives allocation and free requests with bursty timing against a stalling
// result receiver, predicts every result with a ledger of its own and checks
// each result field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import atht_pkg::*;

  localparam int unsigned SLOTS = 1024;

  typedef struct {
    status_e     status;
    logic [47:0] live_bytes;
    logic [31:0] live_count;
    logic [31:0] overflow_count;
    logic [4:0]  class_index;
    logic [31:0] class_count;
    logic [47:0] class_bytes;
    logic [47:0] phase_bytes;
    logic [31:0] phase_count;
  } tracker_result_t;

  // Ledger of live blocks: its own hash table and counters, and the queue of
  // results still to come.
  class alloc_ledger;
    logic [31:0]     slot_addr [SLOTS];
    logic [31:0]     slot_bytes[SLOTS];
    logic [4:0]      slot_tag  [SLOTS];
    logic [31:0]     cls_blocks[32];
    logic [47:0]     cls_bytes [32];
    logic [31:0]     tag_blocks[32];
    logic [47:0]     tag_bytes [32];
    logic [47:0]     live_bytes;
    logic [31:0]     live_blocks;
    logic [31:0]     overflows;
    logic [4:0]      phase;
    int              errors;
    tracker_result_t awaited[$];

    function new();
      for (int i = 0; i < SLOTS; i++) slot_addr[i] = '0;
      for (int i = 0; i < 32; i++) begin
        cls_blocks[i] = '0;
        cls_bytes[i]  = '0;
        tag_blocks[i] = '0;
        tag_bytes[i]  = '0;
      end
      live_bytes  = '0;
      live_blocks = '0;
      overflows   = '0;
      phase       = '0;
      errors      = 0;
    endfunction

    function logic [9:0] home(logic [31:0] a);
      logic [31:0] h;
      h = (a >> 3) * HASH_MULT;
      return h[9:0];
    endfunction

    function logic [4:0] block_class(logic [31:0] n);
      logic [4:0] c;
      c = '0;
      for (int b = 1; b < 32; b++) if (n[b]) c = b[4:0];
      return c;
    endfunction

    function logic [47:0] grow48(logic [47:0] a, logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? '1 : s[47:0];
    endfunction

    function logic [47:0] shrink48(logic [47:0] a, logic [31:0] b);
      return (a > {16'd0, b}) ? a - {16'd0, b} : '0;
    endfunction

    function logic [31:0] grow32(logic [31:0] a);
      return (a == '1) ? a : a + 32'd1;
    endfunction

    function logic [31:0] shrink32(logic [31:0] a);
      return (a == '0) ? a : a - 32'd1;
    endfunction

    // Work out the result of one accepted request and queue it.
    function void note_event(logic func, logic [31:0] a, logic [31:0] sz);
      tracker_result_t r;
      logic [9:0]  i, hole, j;
      logic [4:0]  c, ph;
      logic [31:0] n;
      bit          hit;
      r = '{ST_IGNORED, '0, '0, '0, '0, '0, '0, '0, '0};
      if (a != 0 && func == FUNC_ALLOC) begin
        ph = phase;
        c  = block_class(sz);
        cls_blocks[c] = grow32(cls_blocks[c]);
        cls_bytes[c]  = grow48(cls_bytes[c], sz);
        live_bytes    = grow48(live_bytes, sz);
        live_blocks   = grow32(live_blocks);
        tag_bytes[ph] = grow48(tag_bytes[ph], sz);
        tag_blocks[ph] = grow32(tag_blocks[ph]);
        i   = home(a);
        hit = 0;
        for (int p = 0; p < SLOTS; p++) begin
          if (slot_addr[i] == 0 || slot_addr[i] == a) begin
            slot_addr[i]  = a;
            slot_bytes[i] = sz;
            slot_tag[i]   = ph;
            hit = 1;
            break;
          end
          i = i + 1'b1;
        end
        if (hit) r.status = ST_DONE;
        else begin
          overflows = grow32(overflows);
          r.status  = ST_FULL;
        end
        r.class_index = c;
        r.class_count = cls_blocks[c];
        r.class_bytes = cls_bytes[c];
        r.phase_bytes = tag_bytes[ph];
        r.phase_count = tag_blocks[ph];
      end else if (a != 0) begin
        i   = home(a);
        hit = 0;
        for (int p = 0; p < SLOTS; p++) begin
          if (slot_addr[i] == a) begin
            hit = 1;
            break;
          end
          if (slot_addr[i] == 0) break;
          i = i + 1'b1;
        end
        if (hit) begin
          n  = slot_bytes[i];
          c  = block_class(n);
          ph = slot_tag[i];
          cls_blocks[c] = shrink32(cls_blocks[c]);
          cls_bytes[c]  = shrink48(cls_bytes[c], n);
          live_bytes    = shrink48(live_bytes, n);
          live_blocks   = shrink32(live_blocks);
          tag_bytes[ph] = shrink48(tag_bytes[ph], n);
          tag_blocks[ph] = shrink32(tag_blocks[ph]);
          // Backward-shift delete: pull later entries of the cluster into
          // the hole when their home slot does not lie beyond it.
          hole = i;
          j    = i + 1'b1;
          slot_addr[hole] = '0;
          while (slot_addr[j] != 0) begin
            if (10'(j - home(slot_addr[j])) >= 10'(j - hole)) begin
              slot_addr[hole]  = slot_addr[j];
              slot_bytes[hole] = slot_bytes[j];
              slot_tag[hole]   = slot_tag[j];
              slot_addr[j]     = '0;
              hole = j;
            end
            j = j + 1'b1;
          end
          r.status      = ST_DONE;
          r.class_index = c;
          r.class_count = cls_blocks[c];
          r.class_bytes = cls_bytes[c];
          r.phase_bytes = tag_bytes[ph];
          r.phase_count = tag_blocks[ph];
        end
      end
      r.live_bytes     = live_bytes;
      r.live_count     = live_blocks;
      r.overflow_count = overflows;
      awaited.push_back(r);
    endfunction

    function void compare(string field, logic [47:0] e, logic [47:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
      end
    endfunction

    // Check one result against the oldest expectation.
    function void check_result(tracker_result_t got);
      tracker_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, got.status);
        return;
      end
      e = awaited.pop_front();
      compare("status", 48'(e.status), 48'(got.status));
      compare("live_bytes", e.live_bytes, got.live_bytes);
      compare("live_count", 48'(e.live_count), 48'(got.live_count));
      compare("overflow_count", 48'(e.overflow_count), 48'(got.overflow_count));
      compare("class_index", 48'(e.class_index), 48'(got.class_index));
      compare("class_count", 48'(e.class_count), 48'(got.class_count));
      compare("class_bytes", e.class_bytes, got.class_bytes);
      compare("phase_bytes", e.phase_bytes, got.phase_bytes);
      compare("phase_count", 48'(e.phase_count), 48'(got.phase_count));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [4:0] cfg_data_i;
  logic hold_off = 1'b0;
  int   burst_left = 0;
  logic [31:0] live_addrs[$];
  alloc_ledger ledger = new();

  atht_in_if  req_if ();
  atht_out_if res_if ();

  allocation_tracking_hash_table i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  always #1 clk_i = ~clk_i;

  // Note every accepted request and check every accepted result.
  always @(posedge clk_i) begin
    tracker_result_t got;
    if (req_if.valid && req_if.ready) ledger.note_event(req_if.func, req_if.address, req_if.size);
    if (res_if.valid && res_if.ready) begin
      got.status         = status_e'(res_if.status);
      got.live_bytes     = res_if.live_bytes;
      got.live_count     = res_if.live_count;
      got.overflow_count = res_if.overflow_count;
      got.class_index    = res_if.class_index;
      got.class_count    = res_if.class_count;
      got.class_bytes    = res_if.class_bytes;
      got.phase_bytes    = res_if.phase_bytes;
      got.phase_count    = res_if.phase_count;
      ledger.check_result(got);
    end
  end

  // Receiver: a stall pattern chosen at random, and one long
  // hold-off on request.
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        res_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        if (cyc % 100 == 0) mode = $urandom_range(0, 2);
        cyc++;
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          default: res_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Send one request, idling between bursts of random length.
  task automatic send_req(logic func, logic [31:0] a, logic [31:0] sz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.func    <= func;
    req_if.address <= a;
    req_if.size    <= sz;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Change the phase tag once every outstanding result has come back.
  task automatic set_phase(logic [4:0] v);
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (ledger.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    ledger.phase = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 64);
      default: return 32'd1 << $urandom_range(0, 31);
    endcase
  endfunction

  // Stimulus: directed cases, then random traffic.
  initial begin
    logic [31:0] a, b, c;
    int          idx, r;
    req_if.valid   <= 1'b0;
    req_if.func    <= FUNC_ALLOC;
    req_if.address <= '0;
    req_if.size    <= '0;
    cfg_we_i       <= 1'b0;
    cfg_data_i     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Null addresses, an untracked free and the size extremes.
    send_req(FUNC_ALLOC, 32'h0, 32'h10);
    send_req(FUNC_FREE, 32'h0, 32'h0);
    send_req(FUNC_FREE, 32'h1234, 32'h0);
    send_req(FUNC_ALLOC, 32'h8, 32'h0);
    send_req(FUNC_ALLOC, 32'h10, 32'h1);
    send_req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(FUNC_ALLOC, 32'h18, 32'h8000_0000);
    // Repeated allocation double-counts, then a double free.
    send_req(FUNC_ALLOC, 32'h8, 32'h5);
    send_req(FUNC_FREE, 32'h8, 32'h0);
    send_req(FUNC_FREE, 32'h8, 32'h0);
    // Three addresses sharing one home slot, removed out of order.
    a = 32'h100;
    b = a + 8;
    while (ledger.home(b) != ledger.home(a)) b += 8;
    c = b + 8;
    while (ledger.home(c) != ledger.home(a)) c += 8;
    send_req(FUNC_ALLOC, a, 32'h40);
    send_req(FUNC_ALLOC, b, 32'h41);
    send_req(FUNC_ALLOC, c, 32'h42);
    send_req(FUNC_FREE, a, 32'h0);
    send_req(FUNC_FREE, c, 32'h0);
    send_req(FUNC_FREE, b, 32'h0);
    set_phase(5'd31);
    send_req(FUNC_ALLOC, 32'h20, 32'h3);
    send_req(FUNC_FREE, 32'hFFFF_FFFF, 32'h0);
    send_req(FUNC_FREE, 32'h10, 32'h0);
    send_req(FUNC_FREE, 32'h20, 32'h0);
    send_req(FUNC_FREE, 32'h18, 32'h0);

    // Random traffic in chunks, each under its own phase tag.
    for (int k = 0; k < 8; k++) begin
      set_phase((k == 0) ? 5'd0 : (k == 1) ? 5'd31 : 5'($urandom));
      if (k == 3) hold_off = 1'b1;
      for (int n = 0; n < 104; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45 || (r < 80 && live_addrs.size() == 0)) begin
          a = ($urandom_range(0, 9) == 0) ? $urandom
                                          : (($urandom_range(1, 2047) << 3) | $urandom_range(0, 7));
          if (a != 0) live_addrs.push_back(a);
          send_req(FUNC_ALLOC, a, pick_size());
        end else if (r < 80) begin
          idx = $urandom_range(0, live_addrs.size() - 1);
          a = live_addrs[idx];
          live_addrs.delete(idx);
          send_req(FUNC_FREE, a, $urandom);
        end else if (r < 85 && live_addrs.size() != 0) begin
          send_req(FUNC_ALLOC, live_addrs[$urandom_range(0, live_addrs.size() - 1)], pick_size());
        end else if (r < 90) begin
          send_req(FUNC_FREE, ($urandom_range(1, 2047) << 3) | 32'h7, $urandom);
        end else if (r < 95) begin
          send_req(1'($urandom_range(0, 1)), 32'h0, $urandom);
        end else begin
          send_req(1'($urandom_range(0, 1)), $urandom, $urandom);
        end
      end
    end
    req_if.valid <= 1'b0;

    while (ledger.awaited.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Give up after a generous fixed time.
  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
